// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/trs_pkg.sv =====
package trs_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_W         = 31;
  localparam int ITER_W        = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRAD_TOL  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_TOL  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INIT_RAD  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RAD   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INIT_CURV = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_CURV_FLR  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACC_THR   = 3'd7;

  localparam logic [1:0] ST_MEASURE = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_BEST    = 2'd2;
  localparam logic [1:0] ST_FAIL    = 2'd3;

  localparam logic OP_START = 1'b0;

  // shared serial unit requests
  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_DIV = 2'd1
  } uop_t;
endpackage

// ===== rtl/trust_region_scale_search.sv =====
// Trust-region secant search for one scale value. A start request loads a guess and
// is answered at once with a request to measure it; each measurement request then
// runs a sequence over one shared bit-serial multiply/divide unit: four multiplies
// and three divides when the step is accepted (a zero divisor skips the divide loop);
// a rejected step skips the curvature divide and a first measurement needs one divide
// and one multiply. One request is worked at a time; in_stall is high while a step
// runs or a result waits.
`include "assert_macros.svh"
module trust_region_scale_search #(
  parameter int WORD_BITS = trs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic signed [WORD_BITS-1:0]       in_scale_guess,
  input  logic signed [WORD_BITS-1:0]       in_cost_value,
  input  logic signed [WORD_BITS-1:0]       in_gradient_value,
  input  logic                              in_measure_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [WORD_BITS-1:0]       out_scale_out,
  output logic signed [WORD_BITS-1:0]       out_cost_out,
  output logic [trs_pkg::ITER_W-1:0]        out_steps_used,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [trs_pkg::CFG_W-1:0]         cfg_data
);
  localparam int W  = WORD_BITS;
  localparam int IW = trs_pkg::ITER_W;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] QUARTER = W'(1) <<< (FRAC_BITS - 2);
  localparam logic signed [W-1:0] THREEQ  = QUARTER + (QUARTER <<< 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0,  S_M1 = 4'd2,   S_M2 = 4'd3,
                         S_M3 = 4'd4,    S_Q = 4'd5,     S_RAD = 4'd6, S_H = 4'd7,
                         S_DEC = 4'd8,   S_NEWT = 4'd9,  S_LIM = 4'd10, S_FIN = 4'd11;
  localparam logic [1:0] PH_IDLE = 2'd0, PH_FIRST = 2'd1, PH_STEP = 2'd2;

  // configuration
  logic [IW-1:0]   max_iter_r;
  logic [W-1:0]    grad_tol_r, step_tol_r, init_rad_r, max_rad_r;
  logic [W-1:0]    init_curv_r, curv_flr_r, acc_thr_r;
  logic [W-1:0]    cfg_v;

  assign cfg_ready = 1'b1;
  assign cfg_v = W'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= IW'(50);
      grad_tol_r  <= W'(66);
      step_tol_r  <= W'(66);
      init_rad_r  <= W'(6554);
      max_rad_r   <= W'(655360);
      init_curv_r <= W'(65536);
      curv_flr_r  <= W'(1);
      acc_thr_r   <= W'(7);
    end else if (cfg_valid) begin
      case (cfg_index)
        trs_pkg::REG_MAX_ITER:  max_iter_r  <= cfg_data[IW-1:0];
        trs_pkg::REG_GRAD_TOL:  grad_tol_r  <= cfg_v;
        trs_pkg::REG_STEP_TOL:  step_tol_r  <= cfg_v;
        trs_pkg::REG_INIT_RAD:  init_rad_r  <= cfg_v;
        trs_pkg::REG_MAX_RAD:   max_rad_r   <= cfg_v;
        trs_pkg::REG_INIT_CURV: init_curv_r <= cfg_v;
        trs_pkg::REG_CURV_FLR:  curv_flr_r  <= cfg_v;
        trs_pkg::REG_ACC_THR:   acc_thr_r   <= cfg_v;
        default: ;
      endcase
    end
  end

  // saturating add
  function automatic logic signed [W-1:0] add_s(logic signed [W-1:0] x,
                                                logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sub_s(logic signed [W-1:0] x,
                                                logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} - {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag_f(logic signed [W-1:0] x);
    return x[W-1] ? W'(-x) : W'(x);
  endfunction

  // state
  logic [3:0]            st_r, st_nxt;
  logic [1:0]            ph_r, ph_nxt;
  logic signed [W-1:0]   bscale_r, bscale_nxt, bcost_r, bcost_nxt, bgrad_r, bgrad_nxt;
  logic signed [W-1:0]   curv_r, curv_nxt, rad_r, rad_nxt, pstep_r, pstep_nxt;
  logic                  rhit_r, rhit_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic signed [W-1:0]   cost_r, cost_nxt, grad_r, grad_nxt;
  logic signed [W-1:0]   t1_r, t1_nxt, t2_r, t2_nxt, q_r, q_nxt;
  logic                  ov_r, ov_nxt;
  logic [1:0]            os_r, os_nxt;
  logic signed [W-1:0]   osc_r, osc_nxt, oco_r, oco_nxt;
  logic [IW-1:0]         ost_r, ost_nxt;

  // unit port
  logic                  u_go, u_busy, u_done;
  trs_pkg::uop_t         u_op;
  logic signed [W-1:0]   u_a, u_b, u_res;

  trs_unit #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_unit (
    .clk(clk), .rst_n(rst_n), .go(u_go), .op(u_op), .a(u_a), .b(u_b),
    .busy(u_busy), .done(u_done), .res(u_res)
  );

  logic in_acc, out_acc;
  logic signed [W-1:0] half, expect_v, grown, stp;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (st_r != S_IDLE) || ov_r;

  always_comb begin
    st_nxt = st_r;  ph_nxt = ph_r;
    bscale_nxt = bscale_r; bcost_nxt = bcost_r; bgrad_nxt = bgrad_r;
    curv_nxt = curv_r; rad_nxt = rad_r; pstep_nxt = pstep_r; rhit_nxt = rhit_r;
    cnt_nxt = cnt_r; cost_nxt = cost_r; grad_nxt = grad_r;
    t1_nxt = t1_r; t2_nxt = t2_r; q_nxt = q_r;
    ov_nxt = ov_r && !out_acc;
    os_nxt = os_r; osc_nxt = osc_r; oco_nxt = oco_r; ost_nxt = ost_r;
    u_go = 1'b0; u_op = trs_pkg::UOP_MUL; u_a = '0; u_b = '0;
    half = '0; expect_v = '0; grown = '0; stp = '0;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == trs_pkg::OP_START) begin
            bscale_nxt = in_scale_guess; bcost_nxt = '0; bgrad_nxt = '0;
            curv_nxt = init_curv_r; rad_nxt = init_rad_r; pstep_nxt = '0;
            rhit_nxt = 1'b0; cnt_nxt = '0; ph_nxt = PH_FIRST;
            ov_nxt = 1'b1; os_nxt = trs_pkg::ST_MEASURE; osc_nxt = in_scale_guess;
            oco_nxt = '0; ost_nxt = '0;
          end else if (ph_r == PH_FIRST) begin
            if (!in_measure_ok) begin
              ph_nxt = PH_IDLE; ov_nxt = 1'b1; os_nxt = trs_pkg::ST_FAIL;
              osc_nxt = '0; oco_nxt = '0; ost_nxt = cnt_r;
            end else begin
              bcost_nxt = in_cost_value; bgrad_nxt = in_gradient_value;
              st_nxt = S_DEC;
            end
          end else if (ph_r == PH_STEP) begin
            if (!in_measure_ok) begin
              ph_nxt = PH_IDLE; ov_nxt = 1'b1; os_nxt = trs_pkg::ST_BEST;
              osc_nxt = bscale_r; oco_nxt = bcost_r; ost_nxt = cnt_r;
            end else begin
              cost_nxt = in_cost_value; grad_nxt = in_gradient_value;
              st_nxt = S_M1;
            end
          end
        end
      end
      // g*step
      S_M1: begin
        u_go = !u_busy && !u_done; u_a = bgrad_r; u_b = pstep_r;
        if (u_done) begin t1_nxt = u_res; st_nxt = S_M2; end
      end
      // curvature*step
      S_M2: begin
        u_go = !u_busy && !u_done; u_a = curv_r; u_b = pstep_r;
        if (u_done) begin t2_nxt = u_res; st_nxt = S_M3; end
      end
      // (curvature*step)*step
      S_M3: begin
        u_go = !u_busy && !u_done; u_a = t2_r; u_b = pstep_r;
        if (u_done) begin
          half = $signed(u_res + W'(u_res[W-1])) >>> 1;
          t1_nxt = add_s(t1_r, half);
          st_nxt = S_Q;
        end
      end
      // ratio of actual to predicted
      S_Q: begin
        expect_v = t1_r;
        u_op = trs_pkg::UOP_DIV; u_a = sub_s(cost_r, bcost_r); u_b = expect_v;
        if (expect_v == '0) begin q_nxt = '0; st_nxt = S_RAD; end
        else begin
          u_go = !u_busy && !u_done;
          if (u_done) begin q_nxt = u_res; st_nxt = S_RAD; end
        end
      end
      // radius update, then accept test
      S_RAD: begin
        grown = add_s(rad_r, rad_r);
        if (q_r < QUARTER) rad_nxt = rad_r >>> 2;
        else if (q_r > THREEQ && rhit_r)
          rad_nxt = (grown < $signed(max_rad_r)) ? grown : $signed(max_rad_r);
        if (q_r > $signed(acc_thr_r)) st_nxt = S_H;
        else st_nxt = S_FIN;
      end
      // secant curvature
      S_H: begin
        u_op = trs_pkg::UOP_DIV; u_a = sub_s(grad_r, bgrad_r); u_b = pstep_r;
        u_go = !u_busy && !u_done;
        if (u_done) begin
          curv_nxt = (u_res > $signed(curv_flr_r)) ? u_res : $signed(curv_flr_r);
          bscale_nxt = add_s(bscale_r, pstep_r);
          bcost_nxt = cost_r; bgrad_nxt = grad_r;
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (cnt_r != {IW{1'b1}}) cnt_nxt = cnt_r + 1'b1;
        st_nxt = S_DEC;
      end
      // limit and gradient tests
      S_DEC: begin
        if (cnt_r >= max_iter_r) begin
          ph_nxt = PH_IDLE; ov_nxt = 1'b1; os_nxt = trs_pkg::ST_BEST;
          osc_nxt = bscale_r; oco_nxt = bcost_r; ost_nxt = cnt_r; st_nxt = S_IDLE;
        end else if (mag_f(bgrad_r) < grad_tol_r) begin
          ph_nxt = PH_IDLE; ov_nxt = 1'b1; os_nxt = trs_pkg::ST_DONE;
          osc_nxt = bscale_r; oco_nxt = bcost_r; ost_nxt = cnt_r; st_nxt = S_IDLE;
        end else st_nxt = S_NEWT;
      end
      // newton step, clipped to radius
      S_NEWT: begin
        u_op = trs_pkg::UOP_DIV; u_a = sub_s('0, bgrad_r); u_b = curv_r;
        u_go = !u_busy && !u_done;
        if (u_done) begin
          stp = u_res;
          if (mag_f(stp) <= mag_f(rad_r)) rhit_nxt = (mag_f(stp) == mag_f(rad_r));
          else begin
            stp = stp[W-1] ? W'(-rad_r) : rad_r;
            rhit_nxt = 1'b1;
          end
          pstep_nxt = stp;
          st_nxt = S_LIM;
        end
      end
      // step size tolerance
      S_LIM: begin
        u_a = $signed(step_tol_r); u_b = bscale_r;
        u_go = !u_busy && !u_done;
        if (u_done) begin
          ov_nxt = 1'b1; ost_nxt = cnt_r; st_nxt = S_IDLE;
          if (mag_f(pstep_r) < mag_f(u_res)) begin
            ph_nxt = PH_IDLE; os_nxt = trs_pkg::ST_DONE;
            osc_nxt = bscale_r; oco_nxt = bcost_r;
          end else begin
            ph_nxt = PH_STEP; os_nxt = trs_pkg::ST_MEASURE;
            osc_nxt = add_s(bscale_r, pstep_r); oco_nxt = '0;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_IDLE; ov_r <= 1'b0;
      bscale_r <= '0; bcost_r <= '0; bgrad_r <= '0; curv_r <= '0;
      rad_r <= '0; pstep_r <= '0; rhit_r <= 1'b0; cnt_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ov_r <= ov_nxt;
      bscale_r <= bscale_nxt; bcost_r <= bcost_nxt; bgrad_r <= bgrad_nxt;
      curv_r <= curv_nxt; rad_r <= rad_nxt; pstep_r <= pstep_nxt;
      rhit_r <= rhit_nxt; cnt_r <= cnt_nxt;
    end
    cost_r <= cost_nxt; grad_r <= grad_nxt;
    t1_r <= t1_nxt; t2_r <= t2_nxt; q_r <= q_nxt;
    os_r <= os_nxt; osc_r <= osc_nxt; oco_r <= oco_nxt; ost_r <= ost_nxt;
  end

  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_scale_out  = osc_r;
  assign out_cost_out   = oco_r;
  assign out_steps_used = ost_r;

  `ASSERT_CLK(a_no_take_busy, clk, rst_n, !(in_acc && (st_r != S_IDLE)), "request while busy")
  `ASSERT_NEXT(a_one_result, clk, rst_n, in_acc && in_operation == trs_pkg::OP_START,
               out_valid, "start gives no result")
  `ASSERT_CLK(a_unit_idle, clk, rst_n, !(st_r == S_IDLE && u_busy), "unit busy at idle")
endmodule

// ===== rtl/trs_unit.sv =====
// shared bit-serial multiply / divide unit in fixed point with saturation
module trs_unit #(
  parameter int WORD_BITS = trs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  trs_pkg::uop_t               op,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] b,
  output logic                        busy,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res
);
  localparam int PW  = 2 * WORD_BITS + FRAC_BITS;
  localparam int CW  = $clog2(PW + 1);
  localparam logic [PW-1:0] WMAXP = PW'({1'b0, {(WORD_BITS-1){1'b1}}});

  logic          busy_r, busy_nxt, done_r, done_nxt;
  trs_pkg::uop_t op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, zdiv_r, zdiv_nxt;
  logic [PW-1:0] acc_r, acc_nxt;   // product or quotient
  logic [PW-1:0] sh_r, sh_nxt;     // multiplicand / numerator shifter
  logic [WORD_BITS:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] bm_r, bm_nxt;
  logic signed [WORD_BITS-1:0] res_r, res_nxt;

  logic [WORD_BITS-1:0] ma, mb;
  logic [WORD_BITS:0] rsh, rdif;
  logic [PW-1:0] mag, lim;

  always_comb begin
    ma = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    mb = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    zdiv_nxt = zdiv_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    bm_nxt   = bm_r;
    res_nxt  = res_r;
    rsh      = {rem_r[WORD_BITS-1:0], sh_r[PW-1]};
    rdif     = rsh - {1'b0, bm_r};
    mag      = '0;
    lim      = '0;
    // operand load
    if (go && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      neg_nxt  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
      bm_nxt   = mb;
      acc_nxt  = '0;
      rem_nxt  = '0;
      zdiv_nxt = (mb == '0);
      if (op == trs_pkg::UOP_MUL) begin
        sh_nxt  = PW'(ma);
        cnt_nxt = CW'(WORD_BITS);
      end else begin
        // zero divisor skips the loop so the numerator stays visible
        sh_nxt  = PW'(ma) << FRAC_BITS;
        cnt_nxt = (mb == '0) ? '0 : CW'(PW);
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        // one bit per cycle
        if (op_r == trs_pkg::UOP_MUL) begin
          if (bm_r[0]) acc_nxt = acc_r + sh_r;
          sh_nxt = sh_r << 1;
          bm_nxt = bm_r >> 1;
        end else begin
          sh_nxt = sh_r << 1;
          if (!rdif[WORD_BITS]) begin
            rem_nxt = rdif;
            acc_nxt = {acc_r[PW-2:0], 1'b1};
          end else begin
            rem_nxt = rsh;
            acc_nxt = {acc_r[PW-2:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        // scale, saturate and sign
        if (op_r == trs_pkg::UOP_MUL) mag = acc_r >> FRAC_BITS;
        else if (zdiv_r) mag = (sh_r == '0) ? '0 : {PW{1'b1}};
        else mag = acc_r;
        lim = neg_r ? WMAXP + 1'b1 : WMAXP;
        if (mag > lim) mag = lim;
        res_nxt  = neg_r ? WORD_BITS'(-mag) : WORD_BITS'(mag);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= trs_pkg::UOP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r  <= neg_nxt;
    zdiv_r <= zdiv_nxt;
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    bm_r   <= bm_nxt;
    res_r  <= res_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;
endmodule

// ===== tb/trs_search_checker.sv =====
`timescale 1ns / 1ps
module trs_search_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_operation,
  input  logic signed [31:0]               in_scale_guess,
  input  logic signed [31:0]               in_cost_value,
  input  logic signed [31:0]               in_gradient_value,
  input  logic                             in_measure_ok,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [1:0]                       out_status,
  input  logic signed [31:0]               out_scale_out,
  input  logic signed [31:0]               out_cost_out,
  input  logic [trs_pkg::ITER_W-1:0]       out_steps_used,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [trs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [trs_pkg::CFG_W-1:0]        cfg_data,
  output int                               fail_count,
  output int                               outstanding
);

  localparam longint WMAX = 64'sh7FFF_FFFF;
  localparam longint WMIN = -WMAX - 1;
  localparam longint QUARTER = 64'sd16384;
  localparam longint THREE_QUARTERS = 64'sd49152;

  typedef enum logic [1:0] {SRCH_IDLE, SRCH_FIRST, SRCH_STEP} search_phase_t;

  typedef struct {
    logic [1:0]                 status;
    logic [31:0]                scale;
    logic [31:0]                cost;
    logic [trs_pkg::ITER_W-1:0] steps;
  } search_result_t;

  search_result_t expected_results[$];

  // register copies
  longint lim_iter, tol_grad, tol_step, rad0, rad_max, curv0, curv_min, thr_accept;
  // search state
  search_phase_t srch;
  longint kept_scale, kept_cost, kept_grad, curv, radius, step_pend;
  bit bound_hit;
  int steps_taken;

  function automatic longint sat_w(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic longint mag_of(longint a);
    return a < 0 ? -a : a;
  endfunction

  // clamp a magnitude to the signed range and apply the sign
  function automatic longint signed_from_mag(bit neg, longint m);
    longint lim;
    lim = neg ? WMAX + 1 : WMAX;
    if (m > lim || m < 0) m = lim;
    return neg ? -m : m;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return signed_from_mag((a < 0) != (b < 0), (mag_of(a) * mag_of(b)) >> 16);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint ua, ub;
    ua = mag_of(a);
    ub = mag_of(b);
    if (ub == 0) return ua == 0 ? 0 : signed_from_mag(a < 0, -1);
    return signed_from_mag((a < 0) != (b < 0), (ua << 16) / ub);
  endfunction

  task automatic post_result(logic [1:0] st, longint scale, longint cost);
    search_result_t r;
    r.status = st;
    r.scale = scale[31:0];
    r.cost = cost[31:0];
    r.steps = steps_taken[trs_pkg::ITER_W-1:0];
    expected_results.insert(expected_results.size(), r);
  endtask

  // from the kept point: finish, or ask for the next trial scale
  task automatic plan_next_trial();
    longint step, lim;
    if (steps_taken >= lim_iter) begin
      srch = SRCH_IDLE;
      post_result(trs_pkg::ST_BEST, kept_scale, kept_cost);
      return;
    end
    if (mag_of(kept_grad) < tol_grad) begin
      srch = SRCH_IDLE;
      post_result(trs_pkg::ST_DONE, kept_scale, kept_cost);
      return;
    end
    step = fx_div(sat_w(-kept_grad), curv);
    if (mag_of(step) <= mag_of(radius)) begin
      bound_hit = (mag_of(step) == mag_of(radius));
    end else begin
      step = step >= 0 ? radius : -radius;
      bound_hit = 1;
    end
    lim = fx_mul(tol_step, kept_scale);
    if (mag_of(step) < mag_of(lim)) begin
      srch = SRCH_IDLE;
      post_result(trs_pkg::ST_DONE, kept_scale, kept_cost);
      return;
    end
    step_pend = step;
    srch = SRCH_STEP;
    post_result(trs_pkg::ST_MEASURE, sat_w(kept_scale + step), 0);
  endtask

  task automatic predict_search(logic op, longint guess, longint cost, longint grad, logic ok);
    longint trial, predicted, actual, ratio, h, grown;
    if (op == trs_pkg::OP_START) begin
      kept_scale = guess;
      kept_cost = 0;
      kept_grad = 0;
      curv = curv0;
      radius = rad0;
      step_pend = 0;
      bound_hit = 0;
      steps_taken = 0;
      srch = SRCH_FIRST;
      post_result(trs_pkg::ST_MEASURE, kept_scale, 0);
      return;
    end
    if (srch == SRCH_FIRST) begin
      if (!ok) begin
        srch = SRCH_IDLE;
        post_result(trs_pkg::ST_FAIL, 0, 0);
        return;
      end
      kept_cost = cost;
      kept_grad = grad;
      plan_next_trial();
      return;
    end
    if (srch != SRCH_STEP) return;
    if (!ok) begin
      srch = SRCH_IDLE;
      post_result(trs_pkg::ST_BEST, kept_scale, kept_cost);
      return;
    end
    trial = sat_w(kept_scale + step_pend);
    predicted = sat_w(fx_mul(kept_grad, step_pend) +
                      fx_mul(fx_mul(curv, step_pend), step_pend) / 2);
    actual = sat_w(cost - kept_cost);
    ratio = predicted == 0 ? 0 : fx_div(actual, predicted);
    // radius update
    if (ratio < QUARTER) begin
      radius = radius >>> 2;
    end else if (ratio > THREE_QUARTERS && bound_hit) begin
      grown = sat_w(radius + radius);
      radius = grown < rad_max ? grown : rad_max;
    end
    // acceptance with secant curvature
    if (ratio > thr_accept) begin
      h = fx_div(sat_w(grad - kept_grad), step_pend);
      curv = h > curv_min ? h : curv_min;
      kept_scale = trial;
      kept_cost = cost;
      kept_grad = grad;
    end
    if (steps_taken < 1023) steps_taken++;
    plan_next_trial();
  endtask

  always @(posedge clk) begin
    search_result_t e;
    if (!rst_n) begin
      lim_iter = 50;
      tol_grad = 66;
      tol_step = 66;
      rad0 = 6554;
      rad_max = 655360;
      curv0 = 65536;
      curv_min = 1;
      thr_accept = 7;
      srch = SRCH_IDLE;
      kept_scale = 0;
      kept_cost = 0;
      kept_grad = 0;
      curv = 0;
      radius = 0;
      step_pend = 0;
      bound_hit = 0;
      steps_taken = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // results first: a result leaving now belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: status %0d scale %h cost %h steps %0d",
                     out_status, out_scale_out, out_cost_out, out_steps_used);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.status || out_scale_out !== e.scale ||
              out_cost_out !== e.cost || out_steps_used !== e.steps) begin
            if (fail_count < 10)
              $display("mismatch: exp status %0d scale %h cost %h steps %0d, got %0d %h %h %0d",
                       e.status, e.scale, e.cost, e.steps,
                       out_status, out_scale_out, out_cost_out, out_steps_used);
            fail_count++;
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          trs_pkg::REG_MAX_ITER:  lim_iter = longint'(cfg_data[trs_pkg::ITER_W-1:0]);
          trs_pkg::REG_GRAD_TOL:  tol_grad = longint'(cfg_data);
          trs_pkg::REG_STEP_TOL:  tol_step = longint'(cfg_data);
          trs_pkg::REG_INIT_RAD:  rad0 = longint'(cfg_data);
          trs_pkg::REG_MAX_RAD:   rad_max = longint'(cfg_data);
          trs_pkg::REG_INIT_CURV: curv0 = longint'(cfg_data);
          trs_pkg::REG_CURV_FLR:  curv_min = longint'(cfg_data);
          trs_pkg::REG_ACC_THR:   thr_accept = longint'(cfg_data);
          default: ;
        endcase
      end
      // accepted request
      if (in_valid && !in_stall)
        predict_search(in_operation, longint'(in_scale_guess), longint'(in_cost_value),
                       longint'(in_gradient_value), in_measure_ok);
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/tb_trust_region_scale_search.sv =====
`timescale 1ns / 1ps
module tb_trust_region_scale_search;

  localparam int DRAIN_CYCLES = 600;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_operation = trs_pkg::OP_START;
  logic signed [31:0] in_scale_guess = 0;
  logic signed [31:0] in_cost_value = 0;
  logic signed [31:0] in_gradient_value = 0;
  logic in_measure_ok = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic signed [31:0] out_scale_out;
  logic signed [31:0] out_cost_out;
  logic [trs_pkg::ITER_W-1:0] out_steps_used;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [trs_pkg::CFG_IDX_BITS-1:0] cfg_index = trs_pkg::REG_MAX_ITER;
  logic [trs_pkg::CFG_W-1:0] cfg_data = 0;

  int fail_count;
  int outstanding;
  bit calm = 0;
  int stall_left = 0;
  logic signed [31:0] last_scale = 0;
  logic [1:0] last_status = trs_pkg::ST_DONE;
  longint x0, curv_k, cost0;

  always #4 clk = ~clk;

  trust_region_scale_search DUT (.*);

  trs_search_checker u_checker (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // result stall on the receive side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // track the last requested scale for the measurement model
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_scale <= out_scale_out;
      last_status <= out_status;
    end
  end

  task automatic send_request(logic op, logic [31:0] guess, logic [31:0] cost,
                              logic [31:0] grad, logic ok);
    int n;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk) in_valid <= 0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_operation <= op;
    in_scale_guess <= guess;
    in_cost_value <= cost;
    in_gradient_value <= grad;
    in_measure_ok <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [trs_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [trs_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 0;
  endtask

  function automatic logic [trs_pkg::CFG_W-1:0] pick(int mode, logic [trs_pkg::CFG_W-1:0] lo,
                                                     logic [trs_pkg::CFG_W-1:0] hi,
                                                     int typ_lo, int typ_hi);
    int r;
    r = $urandom_range(0, 9);
    if (mode == 1 || (mode == 0 && r == 0)) return lo;
    if (mode == 2 || (mode == 0 && r == 1)) return hi;
    return trs_pkg::CFG_W'($urandom_range(typ_lo, typ_hi));
  endfunction

  // mode 0 typical with an occasional extreme, 1 all minimum, 2 all maximum
  task automatic write_settings(int mode);
    logic [trs_pkg::CFG_W-1:0] all_ones;
    all_ones = '1;
    write_reg(trs_pkg::REG_MAX_ITER, mode == 2 ? all_ones : pick(mode, 0, 1023, 10, 120));
    write_reg(trs_pkg::REG_GRAD_TOL, pick(mode, 0, all_ones, 1, 3000));
    write_reg(trs_pkg::REG_STEP_TOL, pick(mode, 0, all_ones, 0, 300));
    write_reg(trs_pkg::REG_INIT_RAD, pick(mode, 0, all_ones, 1000, 300000));
    write_reg(trs_pkg::REG_MAX_RAD, pick(mode, 0, all_ones, 10000, 2000000));
    write_reg(trs_pkg::REG_INIT_CURV, pick(mode, 1, all_ones, 2000, 300000));
    write_reg(trs_pkg::REG_CURV_FLR, pick(mode, 1, all_ones, 1, 8000));
    write_reg(trs_pkg::REG_ACC_THR, pick(mode, 0, all_ones, 0, 30000));
  endtask

  task automatic new_landscape();
    x0 = longint'($urandom_range(0, 1048576)) - 524288;
    curv_k = longint'($urandom_range(8192, 400000));
    cost0 = longint'($urandom_range(0, 200000)) - 100000;
  endtask

  // measurement of the quadratic landscape at the requested scale
  task automatic measure_reply();
    longint d, t;
    logic [31:0] c, g;
    @(negedge clk) in_valid <= 0;
    wait (outstanding == 0);
    // let the last requested scale settle
    @(negedge clk);
    d = longint'(last_scale) - x0;
    if (d > 64'sd1073741824) d = 64'sd1073741824;
    if (d < -64'sd1073741824) d = -64'sd1073741824;
    t = (curv_k * d) / 65536;
    if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
    if (t < -64'sh7FFF_FFFF) t = -64'sh7FFF_FFFF;
    c = sat32(t * d / 65536 + cost0);
    g = sat32(2 * t + longint'($urandom_range(0, 64)) - 32);
    send_request(1'b1, $urandom, c, g, $urandom_range(0, 24) != 0);
  endtask

  task automatic fresh_start();
    logic [31:0] guess;
    new_landscape();
    guess = ($urandom_range(0, 9) == 0) ? $urandom
                                         : 32'(x0 + $urandom_range(0, 800000) - 400000);
    send_request(trs_pkg::OP_START, guess, $urandom, $urandom, 1'($urandom));
  endtask

  task automatic random_phase(int n_items);
    int sent, r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        fresh_start();
      end else if (r < 10) begin
        // noise: random content without waiting for the answer
        send_request(1'b1, $urandom, $urandom, $urandom, 1'($urandom));
      end else if (outstanding == 0 && last_status == trs_pkg::ST_MEASURE) begin
        measure_reply();
      end else if (outstanding != 0) begin
        measure_reply();
      end else begin
        fresh_start();
      end
      sent++;
    end
  endtask

  initial begin
    #40_000_000;
    $display("FAIL trust_region_scale_search");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    repeat (2) @(negedge clk);

    // directed: extremes and special cases at reset settings
    send_request(trs_pkg::OP_START, 32'h7FFF_FFFF, 0, 0, 1);
    send_request(1'b1, 0, 32'h1234_5678, 32'h0000_1000, 0);
    send_request(1'b1, 0, 0, 32'h0001_0000, 1);
    send_request(trs_pkg::OP_START, 32'h8000_0000, 0, 0, 0);
    send_request(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_request(1'b1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_request(1'b1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_request(1'b1, 0, 0, 0, 0);
    send_request(trs_pkg::OP_START, 0, 0, 0, 1);
    send_request(1'b1, 0, 32'h0001_0000, 0, 1);
    send_request(trs_pkg::OP_START, 32'h0001_0000, 0, 0, 1);
    send_request(1'b1, 0, 0, 32'h0001_0000, 1);
    send_request(trs_pkg::OP_START, 32'h0003_0000, 0, 0, 1);
    send_request(1'b1, 0, 32'h0002_0000, 32'hFFFF_0000, 1);
    send_request(1'b1, 0, 32'h0001_0000, 32'hFFFF_8000, 1);
    send_request(1'b1, 0, 0, 0, 1);
    drain();

    // random phases with several register settings
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 3);
      if (ph == 1) write_settings(1);
      else if (ph == 2) write_settings(2);
      else if (ph > 0) write_settings(0);
      last_status = trs_pkg::ST_DONE;
      random_phase(ph == 1 || ph == 2 ? 60 : 120);
      drain();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS trust_region_scale_search");
    end else begin
      $display("FAIL trust_region_scale_search");
    end
    $finish;
  end

endmodule
